// File: design/lrf_pkg.sv
// ----------------------------------------------------------------------------
// lrf_pkg
// Shared types and constants of the longest-remaining-first scheduler.
// ----------------------------------------------------------------------------
package lrf_pkg;

    localparam int LRF_MAX_PROCS = 16;
    localparam int LRF_TIME_BITS = 16;
    localparam int PID_W         = 8;

    // request kinds on the input tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } t_state;

    // control from the sequencer to the selector
    typedef struct packed {
        logic clear;   // start of a new scan
        logic sample;  // read data of r_smp_idx is valid this cycle
    } t_sel_ctl;

endpackage

// File: design/longest_remaining_first_scheduler_core.sv
// ----------------------------------------------------------------------------
// longest_remaining_first_scheduler_core
// Preemptive longest-remaining-time-first scheduler over a slot table.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload
//  s_axis    in   tuser: operation; tdata: slot, proc_id, arrival, burst
//  m_axis    out  tuser: idle; tdata: run_slot .. now_time (tick only)
//
//  Load request: writes the slot entry, gives no response.
//  Tick request: the scan reads one table entry per cycle through the single
//  read port, then the ST_WRITE step writes back the chosen entry and ST_DONE
//  builds the response. Reset (i_rst_n low, synchronous) clears the busy bits
//  and time at once; no clearing pass. A stalled m_axis holds the response; a
//  load is still accepted behind it, a tick waits in its last step until the
//  slot frees.
// ----------------------------------------------------------------------------
module longest_remaining_first_scheduler_core
    import lrf_pkg::*;
#(
    parameter int MAX_PROCS = LRF_MAX_PROCS,
    parameter int TIME_BITS = LRF_TIME_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // slot[3:0], proc_id[11:4], arrival[27:12],
                                       // burst[43:28], zero[47:44]
    input  logic        s_axis_tuser,  // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,  // run_slot[3:0], run_id[11:4], finished[12],
                                       // finish_time[28:13], turnaround[44:29],
                                       // waiting[60:45], all_done[61],
                                       // now_time[77:62], zero[79:78]
    output logic        m_axis_tuser   // idle
);

    localparam int TB = TIME_BITS;
    localparam int AW = $clog2(MAX_PROCS);
    localparam int WW = 3 * TB + PID_W;

    // ---------------- input unpack and saturation ----------------
    logic [3:0]       w_slot;
    logic [PID_W-1:0] w_pid_in;
    logic [15:0]      w_arr_in, w_bur_in;
    logic [TB+15:0]   w_arr_ext, w_bur_ext, w_tmax_ext;
    logic [TB-1:0]    w_arr_sat, w_bur_sat;
    logic [AW+3:0]    w_slot_ext;
    logic             w_slot_ok;

    assign w_slot   = s_axis_tdata[3:0];
    assign w_pid_in = s_axis_tdata[11:4];
    assign w_arr_in = s_axis_tdata[27:12];
    assign w_bur_in = s_axis_tdata[43:28];

    assign w_arr_ext  = {{TB{1'b0}}, w_arr_in};
    assign w_bur_ext  = {{TB{1'b0}}, w_bur_in};
    assign w_tmax_ext = {16'b0, {TB{1'b1}}};
    assign w_arr_sat  = (w_arr_ext > w_tmax_ext) ? {TB{1'b1}} : w_arr_ext[TB-1:0];
    assign w_bur_sat  = (w_bur_ext > w_tmax_ext) ? {TB{1'b1}} : w_bur_ext[TB-1:0];

    assign w_slot_ext = {{AW{1'b0}}, w_slot};
    assign w_slot_ok  = w_slot_ext < (AW+4)'(MAX_PROCS);

    // ---------------- state ----------------
    t_state r_state, n_state;
    logic [TB-1:0] r_now, n_now;
    logic [MAX_PROCS-1:0] r_busy, n_busy;   // entry has remaining time
    logic [AW-1:0] r_cnt, n_cnt;            // scan read address
    logic          r_issue, n_issue;
    logic          r_smp_vld, n_smp_vld;
    logic [AW-1:0] r_smp_idx, n_smp_idx;
    logic          r_fin, n_fin;
    logic [TB-1:0] r_tat, n_tat;

    logic          r_m_valid, n_m_valid;
    logic [79:0]   r_m_data, n_m_data;
    logic          r_m_idle, n_m_idle;

    // table ports
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [WW-1:0] w_wdata;
    logic [WW-1:0] w_rdata;

    // selector
    t_sel_ctl         w_ctl;
    logic             w_found;
    logic [AW-1:0]    w_best_idx;
    logic [TB-1:0]    w_best_left, w_best_arr, w_best_orig;
    logic [PID_W-1:0] w_best_pid;

    // helpers
    logic [TB-1:0] w_new_left, w_now_inc, w_wait;
    logic [AW+3:0] w_idx_ext;
    logic [TB+15:0] w_ft_ext, w_tat_ext, w_wait_ext, w_now_ext;
    logic          w_in_acc, w_out_free;

    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_m_valid || m_axis_tready;
    assign w_new_left = w_best_left - TB'(1);
    assign w_now_inc  = (r_now == {TB{1'b1}}) ? r_now : r_now + TB'(1);
    assign w_wait     = (r_tat >= w_best_orig) ? r_tat - w_best_orig : '0;

    assign w_idx_ext  = {4'b0, w_best_idx};
    assign w_ft_ext   = {16'b0, r_now};
    assign w_tat_ext  = {16'b0, r_tat};
    assign w_wait_ext = {16'b0, w_wait};
    assign w_now_ext  = {16'b0, r_now};

    // ---------------- sequencer ----------------
    always_comb begin
        n_state   = r_state;
        n_now     = r_now;
        n_busy    = r_busy;
        n_cnt     = r_cnt;
        n_issue   = r_issue;
        n_smp_vld = 1'b0;
        n_smp_idx = r_cnt;
        n_fin     = r_fin;
        n_tat     = r_tat;
        n_m_valid = r_m_valid && !m_axis_tready;
        n_m_data  = r_m_data;
        n_m_idle  = r_m_idle;
        w_we      = 1'b0;
        w_waddr   = w_slot_ext[AW-1:0];
        w_wdata   = {w_pid_in, w_bur_sat, w_arr_sat, w_bur_sat};
        w_ctl     = '0;
        s_axis_tready = (r_state == ST_IDLE);

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (s_axis_tuser == OP_LOAD) begin
                        if (w_slot_ok) begin
                            w_we = 1'b1;
                            n_busy[w_slot_ext[AW-1:0]] = (w_bur_sat != '0);
                        end
                    end else begin
                        w_ctl.clear = 1'b1;
                        n_cnt       = '0;
                        n_issue     = 1'b1;
                        n_state     = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // one read issued per cycle, compared in the cycle after
                w_ctl.sample = r_smp_vld;
                n_smp_vld    = r_issue;
                if (r_issue) begin
                    n_cnt = r_cnt + AW'(1);
                    if (r_cnt == AW'(MAX_PROCS - 1)) begin
                        n_issue = 1'b0;
                    end
                end
                if (r_smp_vld && (r_smp_idx == AW'(MAX_PROCS - 1))) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                n_now = w_now_inc;
                n_fin = 1'b0;
                if (w_found) begin
                    w_we    = 1'b1;
                    w_waddr = w_best_idx;
                    w_wdata = {w_best_pid, w_best_orig, w_best_arr, w_new_left};
                    n_busy[w_best_idx] = (w_new_left != '0);
                    n_fin   = (w_new_left == '0);
                    // arrival never exceeds the new time, so no underflow
                    n_tat   = w_now_inc - w_best_arr;
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_m_valid = 1'b1;
                    n_m_idle  = !w_found;
                    n_m_data  = '0;
                    n_m_data[61]    = ~|r_busy;
                    n_m_data[77:62] = w_now_ext[15:0];
                    if (w_found) begin
                        n_m_data[3:0]  = w_idx_ext[3:0];
                        n_m_data[11:4] = w_best_pid;
                        if (r_fin) begin
                            n_m_data[12]    = 1'b1;
                            n_m_data[28:13] = w_ft_ext[15:0];
                            n_m_data[44:29] = w_tat_ext[15:0];
                            n_m_data[60:45] = w_wait_ext[15:0];
                        end
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_now     <= '0;
            r_busy    <= '0;
            r_issue   <= 1'b0;
            r_smp_vld <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_now     <= n_now;
            r_busy    <= n_busy;
            r_issue   <= n_issue;
            r_smp_vld <= n_smp_vld;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt     <= n_cnt;
        r_smp_idx <= n_smp_idx;
        r_fin     <= n_fin;
        r_tat     <= n_tat;
        r_m_data  <= n_m_data;
        r_m_idle  <= n_m_idle;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_idle;

    // ---------------- slot table and selector ----------------
    lrf_mem #(
        .DEPTH (MAX_PROCS),
        .WIDTH (WW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_cnt),
        .o_rdata (w_rdata)
    );

    lrf_sel #(
        .MAX_PROCS (MAX_PROCS),
        .TIME_BITS (TIME_BITS)
    ) u_sel (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_idx    (r_smp_idx),
        .i_busy   (r_busy[r_smp_idx]),
        .i_now    (r_now),
        .i_rdata  (w_rdata),
        .o_found  (w_found),
        .o_idx    (w_best_idx),
        .o_left   (w_best_left),
        .o_arrive (w_best_arr),
        .o_orig   (w_best_orig),
        .o_pid    (w_best_pid)
    );

`ifndef SYNTHESIS
    // the chosen entry must still have work when it is written back
    a_best_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE && w_found) |-> r_busy[w_best_idx])
        else $error("chosen slot has no remaining time");

    // table is written only by a load or by the write-back step
    a_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == ST_IDLE || r_state == ST_WRITE))
        else $error("table write outside load or write-back");

    // a finished report never comes from an idle tick
    a_fin_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[12]) |-> !m_axis_tuser)
        else $error("finished flagged on an idle tick");
`endif

endmodule

// File: design/lrf_mem.sv
// ----------------------------------------------------------------------------
// lrf_mem
// Slot table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lrf_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 56
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: design/lrf_sel.sv
// ----------------------------------------------------------------------------
// lrf_sel
// Running max-select over the slot entries streamed out of the table.
// ----------------------------------------------------------------------------
module lrf_sel
    import lrf_pkg::*;
#(
    parameter int MAX_PROCS = LRF_MAX_PROCS,
    parameter int TIME_BITS = LRF_TIME_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_sel_ctl                     i_ctl,
    input  logic [$clog2(MAX_PROCS)-1:0] i_idx,
    input  logic                         i_busy,
    input  logic [TIME_BITS-1:0]         i_now,
    input  logic [3*TIME_BITS+PID_W-1:0] i_rdata,
    output logic                         o_found,
    output logic [$clog2(MAX_PROCS)-1:0] o_idx,
    output logic [TIME_BITS-1:0]         o_left,
    output logic [TIME_BITS-1:0]         o_arrive,
    output logic [TIME_BITS-1:0]         o_orig,
    output logic [PID_W-1:0]             o_pid
);

    localparam int TB = TIME_BITS;
    localparam int AW = $clog2(MAX_PROCS);

    logic [TB-1:0] w_left, w_arrive, w_orig;
    logic [PID_W-1:0] w_pid;
    logic w_take;

    logic r_found;
    logic [AW-1:0] r_idx;
    logic [TB-1:0] r_left, r_arrive, r_orig;
    logic [PID_W-1:0] r_pid;

    assign w_left   = i_rdata[TB-1:0];
    assign w_arrive = i_rdata[2*TB-1:TB];
    assign w_orig   = i_rdata[3*TB-1:2*TB];
    assign w_pid    = i_rdata[3*TB+PID_W-1:3*TB];

    // strict compare keeps the lowest slot on a tie
    assign w_take = i_ctl.sample && i_busy && (w_arrive <= i_now)
                  && (!r_found || (w_left > r_left));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (w_take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_idx    <= i_idx;
            r_left   <= w_left;
            r_arrive <= w_arrive;
            r_orig   <= w_orig;
            r_pid    <= w_pid;
        end
    end

    assign o_found  = r_found;
    assign o_idx    = r_idx;
    assign o_left   = r_left;
    assign o_arrive = r_arrive;
    assign o_orig   = r_orig;
    assign o_pid    = r_pid;

endmodule

// File: test/tb_longest_remaining_first_scheduler_core.sv
// ----------------------------------------------------------------------------
// tb_longest_remaining_first_scheduler_core
// Self-checking bench for the longest-remaining-first scheduler core.
//
// Load and tick requests go in over s_axis. A tick gives one report on m_axis;
// a load gives none. A predictor in this file mirrors the slot table and the
// scheduler time, and builds the report that each accepted tick must give.
// The run has directed cases and randomized batches of short jobs with some
// noise loads. Random gaps on both sides, with one stretch that has none.
// ----------------------------------------------------------------------------
module tb_longest_remaining_first_scheduler_core;
    import lrf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int                     TICK_LATENCY = LRF_MAX_PROCS + 4;
    localparam int                     STALL_LIMIT  = 2000;
    localparam logic [LRF_TIME_BITS-1:0] TIME_TOP   = '1;

    typedef struct packed {
        logic                     op;
        logic [3:0]               slot;
        logic [PID_W-1:0]         pid;
        logic [LRF_TIME_BITS-1:0] arrival;
        logic [LRF_TIME_BITS-1:0] burst;
    } t_request;

    typedef struct packed {
        logic                     idle;
        logic [3:0]               run_slot;
        logic [PID_W-1:0]         run_id;
        logic                     finished;
        logic [LRF_TIME_BITS-1:0] finish_time;
        logic [LRF_TIME_BITS-1:0] turnaround;
        logic [LRF_TIME_BITS-1:0] waiting;
        logic                     all_done;
        logic [LRF_TIME_BITS-1:0] now_time;
    } t_tick_report;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // slot, proc_id, arrival, burst, zero pad
    logic        s_axis_tuser;   // operation
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;   // run_slot, run_id, finished, finish_time,
                                 // turnaround, waiting, all_done, now_time, pad
    logic        m_axis_tuser;   // idle

    longest_remaining_first_scheduler_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // mirror of the slot table and scheduler time
    logic [LRF_TIME_BITS-1:0] remaining [LRF_MAX_PROCS];
    logic [LRF_TIME_BITS-1:0] arrive_at [LRF_MAX_PROCS];
    logic [LRF_TIME_BITS-1:0] burst_len [LRF_MAX_PROCS];
    logic [PID_W-1:0]         pid_of    [LRF_MAX_PROCS];
    logic [LRF_TIME_BITS-1:0] sched_now;

    t_tick_report expected_reports[$];
    t_tick_report got_report;
    t_tick_report want_report;

    int  errors;
    int  n_loads;
    int  n_ticks;
    int  n_checked;
    int  n_finished;
    int  n_idle;
    int  quiet_cycles;
    bit  pace_on;   // random gaps / backpressure enabled

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic void apply_load(input t_request r);
        remaining[r.slot] = r.burst;
        burst_len[r.slot] = r.burst;
        arrive_at[r.slot] = r.arrival;
        pid_of[r.slot]    = r.pid;
    endfunction

    // pick longest remaining among arrived slots, lowest index on a tie
    function automatic t_tick_report schedule_tick();
        int                       best;
        t_tick_report             rep;
        logic [LRF_TIME_BITS-1:0] tat;
        best = -1;
        rep  = '0;
        for (int k = 0; k < LRF_MAX_PROCS; k++) begin
            if (remaining[k] != 0 && arrive_at[k] <= sched_now) begin
                if (best < 0 || remaining[k] > remaining[best])
                    best = k;
            end
        end
        if (sched_now != TIME_TOP)
            sched_now = sched_now + 1'b1;
        rep.idle = (best < 0);
        if (best >= 0) begin
            rep.run_slot = best[3:0];
            rep.run_id   = pid_of[best];
            remaining[best] = remaining[best] - 1'b1;
            if (remaining[best] == 0) begin
                tat              = sched_now - arrive_at[best];
                rep.finished     = 1'b1;
                rep.finish_time  = sched_now;
                rep.turnaround   = tat;
                // saturated time can leave turnaround below the burst
                rep.waiting      = (tat >= burst_len[best]) ? tat - burst_len[best] : '0;
            end
        end
        rep.all_done = 1'b1;
        for (int k = 0; k < LRF_MAX_PROCS; k++)
            if (remaining[k] != 0)
                rep.all_done = 1'b0;
        rep.now_time = sched_now;
        return rep;
    endfunction

    // ------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------
    task automatic send_request(input t_request r);
        int gap;
        gap = (pace_on && $urandom_range(0, 99) < 30) ? $urandom_range(1, 6) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = r.op;
        s_axis_tdata  = {4'b0, r.burst, r.arrival, r.pid, r.slot};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (r.op == OP_LOAD) begin
            apply_load(r);
            n_loads++;
        end else begin
            expected_reports.push_back(schedule_tick());
            n_ticks++;
        end
    endtask

    task automatic send_load(input int slot, input int pid, input int arrival,
                             input int burst);
        t_request r;
        r.op      = OP_LOAD;
        r.slot    = slot[3:0];
        r.pid     = pid[PID_W-1:0];
        r.arrival = arrival[LRF_TIME_BITS-1:0];
        r.burst   = burst[LRF_TIME_BITS-1:0];
        send_request(r);
    endtask

    task automatic send_tick();
        t_request r;
        r     = '0;
        r.op  = OP_TICK;
        r.pid = $urandom;    // payload of a tick is don't-care
        send_request(r);
    endtask

    // hold the sender off until every report is back
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // response side: backpressure, checking, watchdog
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        m_axis_tready = !pace_on || ($urandom_range(0, 99) >= 30);
    end

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_report.idle        = m_axis_tuser;
            got_report.run_slot    = m_axis_tdata[3:0];
            got_report.run_id      = m_axis_tdata[11:4];
            got_report.finished    = m_axis_tdata[12];
            got_report.finish_time = m_axis_tdata[28:13];
            got_report.turnaround  = m_axis_tdata[44:29];
            got_report.waiting     = m_axis_tdata[60:45];
            got_report.all_done    = m_axis_tdata[61];
            got_report.now_time    = m_axis_tdata[77:62];
            if (expected_reports.size() == 0) begin
                $display("%0t ns: unexpected tick report, expected none, got 0x%0h",
                         $time, got_report);
                errors++;
            end else begin
                want_report = expected_reports.pop_front();
                check_field("idle",        want_report.idle,        got_report.idle);
                check_field("run_slot",    want_report.run_slot,    got_report.run_slot);
                check_field("run_id",      want_report.run_id,      got_report.run_id);
                check_field("finished",    want_report.finished,    got_report.finished);
                check_field("finish_time", want_report.finish_time, got_report.finish_time);
                check_field("turnaround",  want_report.turnaround,  got_report.turnaround);
                check_field("waiting",     want_report.waiting,     got_report.waiting);
                check_field("all_done",    want_report.all_done,    got_report.all_done);
                check_field("now_time",    want_report.now_time,    got_report.now_time);
                n_checked++;
                if (want_report.finished) n_finished++;
                if (want_report.idle)     n_idle++;
            end
        end
    end

    // any handshake on either side counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no handshake for %0d cycles", $time, quiet_cycles);
            $display("longest_remaining_first_scheduler_core test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // empty table right after reset: idle report, all done
    task automatic test_empty_table();
        send_tick();
        wait_drained();
    endtask

    // all-ones and all-zeros fields; a slot whose arrival is still ahead
    task automatic test_field_extremes();
        send_load(15, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_load(0, 0, 0, 1);
        send_tick();    // slot 0 runs and completes
        send_tick();    // slot 15 not arrived: idle, but not all done
        send_load(15, 8'hFF, 16'hFFFF, 0);   // zero burst empties it
        send_tick();
        wait_drained();
    endtask

    // equal remaining time goes to the lower slot; longest always wins
    task automatic test_longest_first_and_ties();
        send_load(7, 8'h17, 0, 3);
        send_load(3, 8'h13, 0, 3);
        send_load(9, 8'h19, 0, 2);
        repeat (9) send_tick();
        wait_drained();
    endtask

    // late arrival holds a slot back; reload overwrites a slot mid-run
    task automatic test_arrival_and_reload();
        send_load(5, 8'h55, sched_now + 3, 2);
        send_load(1, 8'h11, 0, 4);
        send_tick();
        send_load(1, 8'hA1, sched_now, 2);
        repeat (6) send_tick();
        wait_drained();
    endtask

    // batches of short jobs near the current time, with some noise loads
    task automatic test_random_schedules(input int n_items);
        int stop_at;
        int n_jobs;
        int n_run;
        int arr;
        int burst;
        stop_at = n_loads + n_ticks + n_items;
        while (n_loads + n_ticks < stop_at) begin
            // one long stretch without any gaps or backpressure
            pace_on = !((n_loads + n_ticks) > stop_at - n_items / 2 &&
                        (n_loads + n_ticks) < stop_at - n_items / 3);
            // empty slots left with huge bursts so short jobs get a turn
            for (int k = 0; k < LRF_MAX_PROCS; k++)
                if (remaining[k] > 64)
                    send_load(k, $urandom, $urandom, 0);
            n_jobs = $urandom_range(1, 6);
            n_run  = $urandom_range(0, 4);
            for (int j = 0; j < n_jobs; j++) begin
                if ($urandom_range(0, 99) < 10) begin
                    send_load($urandom, $urandom, $urandom, $urandom);
                end else begin
                    arr   = sched_now + $urandom_range(0, 12);
                    burst = ($urandom_range(0, 99) < 5) ? 0 : $urandom_range(1, 10);
                    n_run += burst;
                    send_load($urandom, $urandom, arr, burst);
                end
            end
            for (int t = 0; t < n_run; t++) begin
                if ($urandom_range(0, 99) < 8)
                    send_load($urandom, $urandom, sched_now, $urandom_range(1, 6));
                send_tick();
            end
            if ($urandom_range(0, 99) < 25)
                wait_drained();
        end
        pace_on = 1'b1;
        wait_drained();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_LOAD;
        errors        = 0;
        n_loads       = 0;
        n_ticks       = 0;
        n_checked     = 0;
        n_finished    = 0;
        n_idle        = 0;
        pace_on       = 1'b1;
        sched_now     = '0;
        for (int k = 0; k < LRF_MAX_PROCS; k++) begin
            remaining[k] = '0;
            arrive_at[k] = '0;
            burst_len[k] = '0;
            pid_of[k]    = '0;
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_table();
        test_field_extremes();
        test_longest_first_and_ties();
        test_arrival_and_reload();
        test_random_schedules(1700);

        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (2 * TICK_LATENCY) @(posedge i_clk);

        if (expected_reports.size() != 0) begin
            $display("%0d tick reports never arrived", expected_reports.size());
            errors++;
        end
        $display("covered %0d loads and %0d ticks; %0d reports checked, %0d completions",
                 n_loads, n_ticks, n_checked, n_finished);
        $display("idle ticks %0d, with ties, late arrivals, reloads and empty slots",
                 n_idle);
        if (errors == 0) begin
            $display("longest_remaining_first_scheduler_core test passed");
        end else begin
            $display("longest_remaining_first_scheduler_core test failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/lrf_pkg.sv
design/lrf_mem.sv
design/lrf_sel.sv
design/longest_remaining_first_scheduler_core.sv
test/tb_longest_remaining_first_scheduler_core.sv
